>>> hdl/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// Shared widths, constants and helpers for the banded channel equalizer.
// ----------------------------------------------------------------------------
package bce_pkg;

  // number of active bands (1..8); lanes above it never contribute
  localparam int BANDS      = 8;
  localparam int LANES      = 8;
  localparam int STAGES     = 7;

  localparam int CODE_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int DIFF_W     = 24;
  localparam int WT_W       = 19;
  localparam int PROD_W     = 35;
  localparam int PART_W     = 37;
  localparam int SUM_W      = 38;
  localparam int CNT_W      = $clog2(LANES + 1);
  localparam int IDX_W      = $clog2(LANES);
  localparam int Y_W        = 21;
  localparam int RECIP_W    = 25;
  localparam int RECIP_SH   = 26;
  localparam int QUO_W      = 20;
  localparam int RES_W      = 22;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRAP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_HIGH = 2'd2;

  // weight arithmetic, in units of 1/(2*65536) of a band spacing
  localparam logic [DIFF_W-1:0] CTL_SCALE   = DIFF_W'(2 * BANDS);
  localparam logic [DIFF_W-1:0] WRAP_SPAN   = DIFF_W'(2 * BANDS * 65536);
  localparam logic [DIFF_W-1:0] FULL_WEIGHT = DIFF_W'(393216);

  // rounding offset per contributing band: half of 49152
  localparam logic [SUM_W-1:0] HALF_UNIT = SUM_W'(24576);
  localparam int               UNIT_SH   = 14;
  // at or above this the quotient is past full scale for any band count
  localparam logic [Y_W-1:0]   Y_CAP     = Y_W'(3 * BANDS * 65536);

  typedef logic [STAGES-1:0]        stage_en_t;
  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic [WT_W-1:0]          weight_t;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
    abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  // ceil(2^26 / (3*n)) for n = idx+1; exact for dividends below 2^21
  function automatic logic [RECIP_W-1:0] recip(input logic [IDX_W-1:0] idx);
    unique case (idx)
      3'd0:    recip = 25'd22369622;
      3'd1:    recip = 25'd11184811;
      3'd2:    recip = 25'd7456541;
      3'd3:    recip = 25'd5592406;
      3'd4:    recip = 25'd4473925;
      3'd5:    recip = 25'd3728271;
      3'd6:    recip = 25'd3195661;
      3'd7:    recip = 25'd2796203;
      default: recip = 25'd0;
    endcase
  endfunction

endpackage

>>> hdl/banded_channel_equalizer.sv
// ----------------------------------------------------------------------------
// banded_channel_equalizer
// Per-pixel band-weighted correction of a source value by a control value.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the stage registers in order (weights, products,
//   partial sums, sum, scaled value, quotient, result); out_tvalid shows the last.
// Throughput: one item per cycle while the output accepts, set by the seven-stage
//   pipeline with one register per stage; a stall holds only the full stages, bubbles fill.
// Reset (rst_n low, synchronous): all stage valids clear and the configuration
//   registers go to 0; datapath registers are not reset.
// Configuration writes are always accepted (cfg_ready is tied high).
module banded_channel_equalizer (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,   // [15:0] source_value, [31:16] control_value
  input  logic                               in_tlast,   // end_of_line
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // [15:0] result_value
  output logic                               out_tlast,  // end_of_line_out
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bce_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NS = bce_pkg::STAGES;

  // ---- configuration registers --------------------------------------------
  logic                              wrap_r;
  logic [bce_pkg::CFG_DATA_W-1:0]    gains_low_r, gains_high_r;
  logic [2*bce_pkg::CFG_DATA_W-1:0]  gains_all;
  bce_pkg::gain_t                    gain [bce_pkg::LANES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r       <= 1'b0;
      gains_low_r  <= '0;
      gains_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bce_pkg::REG_WRAP:       wrap_r       <= cfg_data[0];
        bce_pkg::REG_GAINS_LOW:  gains_low_r  <= cfg_data;
        bce_pkg::REG_GAINS_HIGH: gains_high_r <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // four 16-bit gains per register, low band in the low bits
  assign gains_all = {gains_high_r, gains_low_r};

  always_comb begin
    for (int j = 0; j < bce_pkg::LANES; j++) begin
      gain[j] = $signed(gains_all[16*j +: 16]);
    end
  end

  // ---- pipeline flow control ----------------------------------------------
  // A stage loads when it is empty or its successor loads this cycle.
  logic [NS-1:0]        vld_r, vld_nxt;
  bce_pkg::stage_en_t   en;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NS-1];

  // ---- side band: source value and end marker ride alongside -----------------
  logic [bce_pkg::CODE_W-1:0] src_r [NS-1];
  logic [NS-1:0]              eol_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      eol_r[0] <= in_tlast;
      src_r[0] <= in_tdata[15:0];
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) eol_r[k] <= eol_r[k-1];
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) src_r[k] <= src_r[k-1];
    end
  end

  // ---- stage 1: band weights ----------------------------------------------
  bce_pkg::weight_t              w1 [bce_pkg::LANES];
  logic [bce_pkg::LANES-1:0]     hit1;

  bce_weight u_weight (
    .clk     (clk),
    .en      (en[0]),
    .wrap_en (wrap_r),
    .ctl_in  (in_tdata[31:16]),
    .w_r     (w1),
    .hit_r   (hit1)
  );

  // ---- stages 2-4: products and sum ----------------------------------------
  logic signed [bce_pkg::SUM_W-1:0] sum4;
  logic [bce_pkg::CNT_W-1:0]        cnt4;

  bce_mac u_mac (
    .clk    (clk),
    .en     (en[3:1]),
    .w_in   (w1),
    .hit_in (hit1),
    .gain   (gain),
    .sum_r  (sum4),
    .cnt_r  (cnt4)
  );

  // ---- stages 5-6: averaged delta -------------------------------------------
  logic [bce_pkg::QUO_W-1:0] quo6;
  logic                      neg6;

  bce_divide u_divide (
    .clk    (clk),
    .en     (en[5:4]),
    .sum_in (sum4),
    .cnt_in (cnt4),
    .quo_r  (quo6),
    .neg_r  (neg6)
  );

  // ---- stage 7: apply delta and clip to full scale ------------------------
  logic signed [bce_pkg::RES_W-1:0] res;
  logic [bce_pkg::CODE_W-1:0]       res_nxt, res_r;

  always_comb begin
    if (neg6) res = $signed(bce_pkg::RES_W'(src_r[NS-2])) - $signed(bce_pkg::RES_W'(quo6));
    else      res = $signed(bce_pkg::RES_W'(src_r[NS-2])) + $signed(bce_pkg::RES_W'(quo6));
    priority if (res < 0)
      res_nxt = '0;
    else if (res > $signed(bce_pkg::RES_W'(16'hFFFF)))
      res_nxt = '1;
    else
      res_nxt = bce_pkg::CODE_W'(res);
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) res_r <= res_nxt;
  end

  assign out_tdata = res_r;
  assign out_tlast = eol_r[NS-1];

endmodule

>>> hdl/bce_weight.sv
// ----------------------------------------------------------------------------
// bce_weight
// Stage 1: triangular band weights and hit flags for every lane.
// ----------------------------------------------------------------------------
module bce_weight (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        wrap_en,
  input  logic [bce_pkg::CODE_W-1:0]  ctl_in,
  output bce_pkg::weight_t            w_r   [bce_pkg::LANES],
  output logic [bce_pkg::LANES-1:0]   hit_r
);

  logic [bce_pkg::DIFF_W-1:0] scaled;

  assign scaled = bce_pkg::DIFF_W'(ctl_in) * bce_pkg::CTL_SCALE;

  for (genvar j = 0; j < bce_pkg::LANES; j++) begin : g_lane
    localparam logic [bce_pkg::DIFF_W-1:0] BASE = bce_pkg::DIFF_W'((2 * j + 1) * 65536);

    logic signed [bce_pkg::DIFF_W-1:0] d0, d1;
    logic [bce_pkg::DIFF_W-1:0]        a0, a1;
    logic                              h0, h1;
    bce_pkg::weight_t                  w_nxt;
    logic                              hit_nxt;

    always_comb begin
      d0 = $signed(BASE - scaled);
      // shifted copy: ctl+1 below one half, ctl-1 otherwise
      d1 = ctl_in[bce_pkg::CODE_W-1] ? $signed(d0 + bce_pkg::WRAP_SPAN)
                                     : $signed(d0 - bce_pkg::WRAP_SPAN);
      a0 = bce_pkg::abs_diff(d0);
      a1 = bce_pkg::abs_diff(d1);
      h0 = a0 < bce_pkg::FULL_WEIGHT;
      h1 = wrap_en && (a1 < bce_pkg::FULL_WEIGHT);
      if (j >= bce_pkg::BANDS) begin
        hit_nxt = 1'b0;
        w_nxt   = '0;
      end else if (h0) begin
        hit_nxt = 1'b1;
        w_nxt   = bce_pkg::WT_W'(bce_pkg::FULL_WEIGHT - a0);
      end else if (h1) begin
        hit_nxt = 1'b1;
        w_nxt   = bce_pkg::WT_W'(bce_pkg::FULL_WEIGHT - a1);
      end else begin
        hit_nxt = 1'b0;
        w_nxt   = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w_r[j]   <= w_nxt;
        hit_r[j] <= hit_nxt;
      end
    end
  end

endmodule

>>> hdl/bce_mac.sv
// ----------------------------------------------------------------------------
// bce_mac
// Stages 2-4: weight times gain per lane, then a two-level registered sum.
// ----------------------------------------------------------------------------
module bce_mac (
  input  logic                              clk,
  input  logic [2:0]                        en,
  input  bce_pkg::weight_t                  w_in   [bce_pkg::LANES],
  input  logic [bce_pkg::LANES-1:0]         hit_in,
  input  bce_pkg::gain_t                    gain   [bce_pkg::LANES],
  output logic signed [bce_pkg::SUM_W-1:0]  sum_r,
  output logic [bce_pkg::CNT_W-1:0]         cnt_r
);

  localparam int HALF = bce_pkg::LANES / 2;

  logic signed [bce_pkg::PROD_W-1:0] prod_r   [bce_pkg::LANES];
  logic signed [bce_pkg::PROD_W-1:0] prod_nxt [bce_pkg::LANES];
  logic [bce_pkg::CNT_W-1:0]         cnt2_r, cnt3_r;
  logic signed [bce_pkg::PART_W-1:0] part_r   [2];
  logic signed [bce_pkg::PART_W-1:0] part_nxt [2];

  always_comb begin
    for (int j = 0; j < bce_pkg::LANES; j++) begin
      prod_nxt[j] = hit_in[j] ?
        bce_pkg::PROD_W'($signed({1'b0, w_in[j]}) * gain[j]) : '0;
    end
  end

  always_comb begin
    part_nxt[0] = '0;
    part_nxt[1] = '0;
    for (int j = 0; j < HALF; j++) begin
      part_nxt[0] = part_nxt[0] + bce_pkg::PART_W'(prod_r[j]);
      part_nxt[1] = part_nxt[1] + bce_pkg::PART_W'(prod_r[j + HALF]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= prod_nxt;
      cnt2_r <= bce_pkg::CNT_W'($countones(hit_in));
    end
    if (en[1]) begin
      part_r <= part_nxt;
      cnt3_r <= cnt2_r;
    end
    if (en[2]) begin
      sum_r <= bce_pkg::SUM_W'(part_r[0]) + bce_pkg::SUM_W'(part_r[1]);
      cnt_r <= cnt3_r;
    end
  end

endmodule

>>> hdl/bce_divide.sv
// ----------------------------------------------------------------------------
// bce_divide
// Stages 5-6: rounded magnitude divide by 49152*n via reciprocal multiply.
// ----------------------------------------------------------------------------
module bce_divide (
  input  logic                              clk,
  input  logic [1:0]                        en,
  input  logic signed [bce_pkg::SUM_W-1:0]  sum_in,
  input  logic [bce_pkg::CNT_W-1:0]         cnt_in,
  output logic [bce_pkg::QUO_W-1:0]         quo_r,
  output logic                              neg_r
);

  localparam int PROD_W = bce_pkg::Y_W + bce_pkg::RECIP_W;

  logic [bce_pkg::SUM_W-1:0]  mag, xr;
  logic [bce_pkg::SUM_W-1:0]  y_full;
  logic [bce_pkg::Y_W-1:0]    y_nxt, y_r;
  logic [bce_pkg::IDX_W-1:0]  idx_r;
  logic                       neg5_r;
  logic [PROD_W-1:0]          prod;

  always_comb begin
    mag    = sum_in[bce_pkg::SUM_W-1] ? bce_pkg::SUM_W'(-sum_in) : bce_pkg::SUM_W'(sum_in);
    xr     = mag + bce_pkg::HALF_UNIT * bce_pkg::SUM_W'(cnt_in);
    y_full = xr >> bce_pkg::UNIT_SH;
    // saturate: anything past the cap clips at the output anyway
    y_nxt  = (y_full > bce_pkg::SUM_W'(bce_pkg::Y_CAP)) ? bce_pkg::Y_CAP
                                                       : bce_pkg::Y_W'(y_full);
  end

  // no contributing band gives y = 0, so the index wrap is harmless
  assign prod = PROD_W'(y_r) * PROD_W'(bce_pkg::recip(idx_r));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y_r    <= y_nxt;
      idx_r  <= bce_pkg::IDX_W'(cnt_in - bce_pkg::CNT_W'(1));
      neg5_r <= sum_in[bce_pkg::SUM_W-1];
    end
    if (en[1]) begin
      quo_r <= bce_pkg::QUO_W'(prod >> bce_pkg::RECIP_SH);
      neg_r <= neg5_r;
    end
  end

endmodule

>>> hdl/bce_checker.sv
// ----------------------------------------------------------------------------
// bce_checker
// Port-level checks on the equalizer's stream behavior, bound to the top.
// ----------------------------------------------------------------------------
module bce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // input back-pressure only when the output is stalled with a full pipe
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");

  // an accepted item reaches the output if out_tready stays high behind it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready
      ##1 out_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("item missing after pipeline latency");

endmodule

bind banded_channel_equalizer bce_checker u_bce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
